// File: rtl/core/pid_positional_incremental_top_macros.svh
// Assertion macros for the PID controller block.
// PIDPI_ASSERT_RST checks a property with the reset as a disable condition,
// PIDPI_ASSERT checks it at every clock edge, reset included.
`ifndef PID_POSITIONAL_INCREMENTAL_TOP_MACROS_SVH
`define PID_POSITIONAL_INCREMENTAL_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define PIDPI_ASSERT_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pidpi assertion failed");
`define PIDPI_ASSERT(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("pidpi assertion failed");
`else
`define PIDPI_ASSERT_RST(lbl, clk, rst_n, prop)
`define PIDPI_ASSERT(lbl, clk, prop)
`endif
`endif

// File: rtl/core/pidpi_pkg.sv
package pidpi_pkg;

    localparam int GAIN_W     = 16;
    localparam int LIM_W      = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE           = 3'd0,
        CFG_GAIN_P         = 3'd1,
        CFG_GAIN_I         = 3'd2,
        CFG_GAIN_D         = 3'd3,
        CFG_OUT_UPPER      = 3'd4,
        CFG_OUT_LOWER      = 3'd5,
        CFG_INTEGRAL_LIMIT = 3'd6,
        CFG_DEAD_BAND      = 3'd7
    } t_cfg_idx;

    // Controller form selected by the mode register.
    localparam logic MODE_POSITIONAL  = 1'b0;
    localparam logic MODE_INCREMENTAL = 1'b1;

    typedef struct packed {
        logic                     mode;
        logic signed [GAIN_W-1:0] gain_p;
        logic signed [GAIN_W-1:0] gain_i;
        logic signed [GAIN_W-1:0] gain_d;
        logic [LIM_W-1:0]         out_upper;
        logic signed [GAIN_W-1:0] out_lower;
        logic [LIM_W-1:0]         integral_limit;
        logic [LIM_W-1:0]         dead_band;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        mode:           MODE_POSITIONAL,
        gain_p:         16'sd256,
        gain_i:         16'sd0,
        gain_d:         16'sd0,
        out_upper:      15'h7FFF,
        out_lower:      16'sh8000,
        integral_limit: 15'h7FFF,
        dead_band:      15'h0000
    };

endpackage

// File: rtl/core/pidpi_cfg.sv
module pidpi_cfg (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_we,
    input  logic [pidpi_pkg::CFG_IDX_W-1:0]       i_idx,
    input  logic [pidpi_pkg::CFG_DATA_W-1:0]      i_wdata,
    output pidpi_pkg::t_cfg                       o_cfg
);

    pidpi_pkg::t_cfg r_cfg;
    pidpi_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_we) begin
            case (pidpi_pkg::t_cfg_idx'(i_idx))
                pidpi_pkg::CFG_MODE:           n_cfg.mode = i_wdata[0];
                pidpi_pkg::CFG_GAIN_P:         n_cfg.gain_p = $signed(i_wdata);
                pidpi_pkg::CFG_GAIN_I:         n_cfg.gain_i = $signed(i_wdata);
                pidpi_pkg::CFG_GAIN_D:         n_cfg.gain_d = $signed(i_wdata);
                pidpi_pkg::CFG_OUT_UPPER:
                    n_cfg.out_upper = i_wdata[pidpi_pkg::LIM_W-1:0];
                pidpi_pkg::CFG_OUT_LOWER:      n_cfg.out_lower = $signed(i_wdata);
                pidpi_pkg::CFG_INTEGRAL_LIMIT:
                    n_cfg.integral_limit = i_wdata[pidpi_pkg::LIM_W-1:0];
                pidpi_pkg::CFG_DEAD_BAND:
                    n_cfg.dead_band = i_wdata[pidpi_pkg::LIM_W-1:0];
                default:                       n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= pidpi_pkg::CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/core/pidpi_datapath.sv
module pidpi_datapath #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 8,
    parameter int SUM_WIDTH  = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_fire,
    input  logic signed [DATA_WIDTH-1:0] i_err,
    input  pidpi_pkg::t_cfg              i_cfg,
    output logic signed [DATA_WIDTH-1:0] o_drive
);

    localparam int GW  = pidpi_pkg::GAIN_W;
    localparam int LW  = pidpi_pkg::LIM_W;
    localparam int ESW = (SUM_WIDTH > DATA_WIDTH) ? SUM_WIDTH : DATA_WIDTH;
    localparam int AW  = GW + ESW + 4;
    localparam int MW  = (DATA_WIDTH + 1 > LW) ? DATA_WIDTH + 1 : LW;

    localparam logic signed [ESW:0] SUM_MAX =
        {{(ESW - SUM_WIDTH + 2){1'b0}}, {(SUM_WIDTH - 1){1'b1}}};
    localparam logic signed [ESW:0] SUM_MIN = ~SUM_MAX;
    localparam logic signed [AW-1:0] DATA_MAX =
        {{(AW - DATA_WIDTH + 1){1'b0}}, {(DATA_WIDTH - 1){1'b1}}};
    localparam logic signed [AW-1:0] DATA_MIN = ~DATA_MAX;

    logic signed [DATA_WIDTH-1:0] r_prev, n_prev;
    logic signed [DATA_WIDTH-1:0] r_pprev, n_pprev;
    logic signed [DATA_WIDTH-1:0] r_held, n_held;
    logic signed [ESW-1:0]        r_sum, n_sum;
    logic                         r_first, n_first;

    logic                         w_incr;
    logic signed [DATA_WIDTH-1:0] w_prev_eff;
    logic signed [DATA_WIDTH:0]   w_d1;
    logic signed [DATA_WIDTH+1:0] w_d2;
    logic signed [ESW:0]          w_sum_add;
    logic signed [ESW-1:0]        w_sum_sat;
    logic signed [DATA_WIDTH:0]   w_p_opd;
    logic signed [DATA_WIDTH+1:0] w_d_opd;
    logic signed [ESW-1:0]        w_i_opd;
    logic signed [GW+DATA_WIDTH:0]   w_prod_p;
    logic signed [GW+DATA_WIDTH+1:0] w_prod_d;
    logic signed [GW+ESW-1:0]        w_prod_i;
    logic signed [AW-1:0]         w_p_term, w_d_term, w_i_raw, w_i_term;
    logic signed [AW-1:0]         w_il, w_upper, w_lower;
    logic signed [AW-1:0]         w_pos, w_inc, w_lim;
    logic signed [AW-1:0]         w_sat;
    logic signed [DATA_WIDTH:0]   w_e_ext;
    logic [DATA_WIDTH:0]          w_mag;
    logic                         w_dead;

    always_comb begin
        w_incr     = (i_cfg.mode == pidpi_pkg::MODE_INCREMENTAL);
        // A positional first sample sees itself as the previous error.
        w_prev_eff = (!w_incr && r_first) ? i_err : r_prev;
        w_d1 = (DATA_WIDTH+1)'(i_err) - (DATA_WIDTH+1)'(w_prev_eff);
        w_d2 = (DATA_WIDTH+2)'(i_err) + (DATA_WIDTH+2)'(r_pprev)
             - ((DATA_WIDTH+2)'(r_prev) <<< 1);

        w_sum_add = (ESW+1)'(r_sum) + (ESW+1)'(i_err);
        if (w_sum_add > SUM_MAX) begin
            w_sum_sat = ESW'(SUM_MAX);
        end else if (w_sum_add < SUM_MIN) begin
            w_sum_sat = ESW'(SUM_MIN);
        end else begin
            w_sum_sat = ESW'(w_sum_add);
        end

        // The three multipliers are shared between the two forms.
        w_p_opd = w_incr ? w_d1 : (DATA_WIDTH+1)'(i_err);
        w_d_opd = w_incr ? w_d2 : (DATA_WIDTH+2)'(w_d1);
        w_i_opd = w_incr ? ESW'(i_err) : w_sum_sat;

        w_prod_p = $signed(i_cfg.gain_p) * w_p_opd;
        w_prod_d = $signed(i_cfg.gain_d) * w_d_opd;
        w_prod_i = $signed(i_cfg.gain_i) * w_i_opd;

        // Arithmetic shifts round toward minus infinity.
        w_p_term = AW'(w_prod_p >>> FRAC_BITS);
        w_d_term = AW'(w_prod_d >>> FRAC_BITS);
        w_i_raw  = AW'(w_prod_i >>> FRAC_BITS);

        w_il    = $signed(AW'(i_cfg.integral_limit));
        w_upper = $signed(AW'(i_cfg.out_upper));
        w_lower = AW'(i_cfg.out_lower);

        if (w_i_raw > w_il) begin
            w_i_term = w_il;
        end else if (w_i_raw < -w_il) begin
            w_i_term = -w_il;
        end else begin
            w_i_term = w_i_raw;
        end

        // The lower limit is applied last, so it wins when the limits cross.
        w_pos = w_p_term + w_i_term + w_d_term;
        if (w_pos > w_upper) begin
            w_pos = w_upper;
        end
        if (w_pos < w_lower) begin
            w_pos = w_lower;
        end

        w_inc = AW'(r_held) + w_p_term + w_i_term + w_d_term;
        if (w_inc > w_upper) begin
            w_inc = w_upper;
        end else if (w_inc < -w_upper) begin
            w_inc = -w_upper;
        end

        w_lim = w_incr ? w_inc : w_pos;
        if (w_lim > DATA_MAX) begin
            w_sat = DATA_MAX;
        end else if (w_lim < DATA_MIN) begin
            w_sat = DATA_MIN;
        end else begin
            w_sat = w_lim;
        end

        w_e_ext = (DATA_WIDTH+1)'(i_err);
        w_mag   = w_e_ext[DATA_WIDTH] ? -w_e_ext : w_e_ext;
        w_dead  = MW'(w_mag) < MW'(i_cfg.dead_band);
        o_drive = w_dead ? '0 : DATA_WIDTH'(w_sat);
    end

    always_comb begin
        n_prev  = r_prev;
        n_pprev = r_pprev;
        n_held  = r_held;
        n_sum   = r_sum;
        n_first = r_first;
        if (i_fire) begin
            n_held = o_drive;
            n_prev = i_err;
            if (w_incr) begin
                n_sum   = ESW'(i_err);
                n_pprev = r_prev;
            end else begin
                n_sum   = w_sum_sat;
                n_first = 1'b0;
                if (r_first) begin
                    n_pprev = i_err;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= '0;
            r_pprev <= '0;
            r_held  <= '0;
            r_sum   <= '0;
            r_first <= 1'b1;
        end else begin
            r_prev  <= n_prev;
            r_pprev <= n_pprev;
            r_held  <= n_held;
            r_sum   <= n_sum;
            r_first <= n_first;
        end
    end

endmodule

// File: rtl/core/pid_positional_incremental_top.sv
// PID controller, positional or incremental form, signed fixed point.
// The input channel (i_in_valid, o_in_stall, i_error_in) carries one error
// sample per transfer; the output channel (o_out_valid, i_out_stall, o_drive)
// carries exactly one drive value per input transfer, in the same order.
// A transfer happens at a rising edge where valid is high and stall is low.
// Registers are written through i_cfg_we, i_cfg_idx and i_cfg_wdata, and
// should only change while no sample is in flight.
// A sample taken at an edge is registered in the input stage, processed by
// the datapath, and its drive value is registered in the output stage.
// Throughput: one sample per cycle while the receiver does not stall. That
// rate is set by the controller state loop (error history, error sum and
// kept output), which is closed around the three gain multipliers.
// When the receiver stalls, the drive value is held in the output register
// and the stage behind it keeps its sample; the input is stalled only when
// both are full, so one further sample is still taken while a result waits.
// Synchronous reset empties both stages, restores the register defaults
// and clears the error history; the next positional sample seeds it.
`include "pid_positional_incremental_top_macros.svh"

module pid_positional_incremental_top #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 8,
    parameter int SUM_WIDTH  = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [DATA_WIDTH-1:0]         i_error_in,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [DATA_WIDTH-1:0]         o_drive,
    input  logic                                 i_cfg_we,
    input  logic [pidpi_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [pidpi_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    pidpi_pkg::t_cfg w_cfg;

    // Input register stage.
    logic                         r_in_vld;
    logic signed [DATA_WIDTH-1:0] r_in_err;
    // Output register stage.
    logic                         r_out_vld;
    logic signed [DATA_WIDTH-1:0] r_out_drive;

    logic                         w_advance;
    logic                         w_fire;
    logic                         w_in_acc;
    logic signed [DATA_WIDTH-1:0] w_drive_next;

    // The output register can take a new value when it is empty or being
    // drained in this cycle; the sample in the input stage then completes.
    assign w_advance  = !r_out_vld || !i_out_stall;
    assign w_fire     = r_in_vld && w_advance;
    assign o_in_stall = r_in_vld && !w_advance;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    pidpi_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_wdata (i_cfg_wdata),
        .o_cfg   (w_cfg)
    );

    pidpi_datapath #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS),
        .SUM_WIDTH  (SUM_WIDTH)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_err   (r_in_err),
        .i_cfg   (w_cfg),
        .o_drive (w_drive_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_vld <= i_in_valid;
            end
            if (w_advance) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_err <= i_error_in;
        end
        if (w_fire) begin
            r_out_drive <= w_drive_next;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_drive     = r_out_drive;

    // Reset leaves both stages empty and the input open.
    `PIDPI_ASSERT(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid && !o_in_stall)
    // The input is only held off by a full, stalled output register.
    `PIDPI_ASSERT_RST(a_stall_cause, i_clk, i_rst_n, o_in_stall |-> o_out_valid && i_out_stall)
    // A sample that cannot complete stays in the input stage untouched.
    `PIDPI_ASSERT_RST(a_in_hold, i_clk, i_rst_n, r_in_vld && !w_advance |=> r_in_vld && $stable(r_in_err))

endmodule
